FILE: rtl/core/pbr_pkg.sv
// Shared types, constants and the helper function of the planar ByteRun1 line decoder.
`default_nettype none
package pbr_pkg;
   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_PLANES  = 8;
   localparam int STORE_DEPTH = MAX_WIDTH / 8;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int WORD_W      = 64;
   localparam int CSR_IW      = 3;
   localparam int CSR_DW      = 16;

   localparam logic [CSR_IW-1:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IW-1:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IW-1:0] REG_PLANE_COUNT  = 3'd2;
   localparam logic [CSR_IW-1:0] REG_COMP_MODE    = 3'd3;
   localparam logic [CSR_IW-1:0] REG_MASK_PLANE   = 3'd4;

   localparam logic [7:0] MODE_NONE     = 8'd0;
   localparam logic [7:0] MODE_BYTERUN1 = 8'd1;
   localparam logic [7:0] HDR_NOP       = 8'h80;
   localparam logic [8:0] RUN_BASE      = 9'h101;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_OVERRUN = 2'd1;
   localparam logic [1:0] STATUS_EARLY   = 2'd2;
   localparam logic [1:0] STATUS_UNSUP   = 2'd3;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_LITERAL,
      PH_RUN,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      CLS_IGNORE,
      CLS_ERROR,
      CLS_HEADER,
      CLS_STORE
   } cls_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_WRITE,
      ST_END,
      ST_FLUSH,
      ST_ERROR
   } state_type;

   typedef struct packed {
      logic accept;
      logic read;
      logic write;
      logic end_chk;
      logic flush;
      logic err_push;
   } cmd_type;

   typedef struct packed {
      cls_type cls;
      logic    store_last;
      logic    wr_stall;
      logic    pend_valid;
      logic    end_err;
      logic    out_free;
   } stat_type;

   // Spreads the eight bits of a plane byte over eight pixels, MSB to pixel 0.
   function automatic logic [WORD_W-1:0] expand_byte(input logic [7:0] b);
      logic [WORD_W-1:0] w;
      w = '0;
      for (int i = 0; i < 8; i++) begin
         w[8*i] = b[7-i];
      end
      return w;
   endfunction
endpackage
`default_nettype wire

FILE: rtl/core/pbr_ctrl.sv
// Controller state machine that sequences header decode, store updates and result transfers.
`default_nettype none
module pbr_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire pbr_pkg::stat_type  stat,
   output pbr_pkg::cmd_type        cmd
);
   import pbr_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (stat.cls)
                  CLS_IGNORE: state_in = ST_IDLE;
                  CLS_ERROR:  state_in = ST_ERROR;
                  CLS_HEADER: state_in = ST_END;
                  CLS_STORE:  state_in = ST_READ;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ:  state_in = ST_WRITE;
         ST_WRITE: begin
            if (!stat.wr_stall) begin
               state_in = stat.store_last ? ST_END : ST_READ;
            end
         end
         ST_END: begin
            if (stat.end_err) begin
               state_in = ST_ERROR;
            end else if (stat.pend_valid) begin
               state_in = ST_FLUSH;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FLUSH: if (stat.out_free) state_in = ST_IDLE;
         ST_ERROR: if (stat.out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_READ:  cmd.read     = 1'b1;
         ST_WRITE: cmd.write    = !stat.wr_stall;
         ST_END:   cmd.end_chk  = 1'b1;
         ST_FLUSH: cmd.flush    = stat.out_free;
         ST_ERROR: cmd.err_push = stat.out_free;
         default: begin
            cmd       = '0;
            req_ready = 1'b0;
         end
      endcase
   end
endmodule
`default_nettype wire

FILE: rtl/core/pbr_datapath.sv
// Datapath: configuration, decode state, line store, pending group and result register.
`default_nettype none
module pbr_datapath (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire pbr_pkg::cmd_type           cmd,
   output pbr_pkg::stat_type               stat,
   input  wire logic [7:0]                 req_data_byte,
   input  wire logic                       req_chunk_end,
   input  wire logic                       csr_write,
   input  wire logic [pbr_pkg::CSR_IW-1:0] csr_index,
   input  wire logic [pbr_pkg::CSR_DW-1:0] csr_data,
   input  wire logic                       rsp_ready,
   output logic                            rsp_valid,
   output logic [63:0]                     rsp_pixels_first,
   output logic [63:0]                     rsp_pixels_second,
   output logic [9:0]                      rsp_column,
   output logic [15:0]                     rsp_row,
   output logic [4:0]                      rsp_valid_pixels,
   output logic [1:0]                      rsp_status,
   output logic                            rsp_last_of_item,
   output logic                            rsp_image_done
);
   import pbr_pkg::*;

   // Configuration registers.
   logic [10:0] width_ff;
   logic [15:0] height_ff;
   logic [3:0]  planes_ff;
   logic [7:0]  mode_ff;
   logic        mask_ff;

   // Decode state.
   logic [3:0]  plane_ff, plane_in;
   logic        in_mask_ff, in_mask_in;
   logic [7:0]  pos_ff, pos_in;
   logic [15:0] row_ff, row_in;
   phase_type   phase_ff, phase_in;
   logic [7:0]  lit_ff, lit_in;
   logic        err_flag_ff;
   logic [1:0]  err_code_ff;

   // Current item.
   logic [7:0]  byte_ff;
   logic        ce_ff;
   logic [7:0]  count_ff;
   logic        lit_step_ff;

   logic [WORD_W-1:0] store_mem [STORE_DEPTH];
   logic [WORD_W-1:0] rd_word_ff;
   logic [WORD_W-1:0] prev_word_ff;

   // Group that waits until it is known whether it closes the item.
   logic        pend_valid_ff;
   logic [63:0] pend_p1_ff, pend_p2_ff;
   logic [9:0]  pend_col_ff;
   logic [15:0] pend_row_ff;
   logic [4:0]  pend_vp_ff;
   logic [1:0]  pend_status_ff;
   logic        pend_done_ff;

   logic        out_valid_ff;
   logic [63:0] out_p1_ff, out_p2_ff;
   logic [9:0]  out_col_ff;
   logic [15:0] out_row_ff;
   logic [4:0]  out_vp_ff;
   logic [1:0]  out_status_ff;
   logic        out_last_ff;
   logic        out_done_ff;

   logic [10:0] eff_width;
   logic [10:0] width_sum;
   logic [7:0]  line_len;
   logic [3:0]  eff_planes;
   logic [15:0] eff_height;
   logic        row_last;
   cls_type     cls;
   logic [1:0]  cls_code;
   logic [9:0]  lit_need;
   logic [9:0]  run_need;

   logic [WORD_W-1:0] exp_word;
   logic [WORD_W-1:0] new_word;
   logic [7:0]  pos_next;
   logic        line_done;
   logic        last_col;
   logic        emit;
   logic [9:0]  grp_col;
   logic [10:0] width_left;
   logic [4:0]  grp_vp;
   logic        grp_done;
   logic        out_free;

   always_comb begin
      if (width_ff == 11'd0) begin
         eff_width = 11'd1;
      end else if (width_ff > 11'(MAX_WIDTH)) begin
         eff_width = 11'(MAX_WIDTH);
      end else begin
         eff_width = width_ff;
      end
      width_sum = eff_width + 11'd15;
      line_len  = {width_sum[10:4], 1'b0};
      if (planes_ff == 4'd0) begin
         eff_planes = 4'd1;
      end else if (planes_ff > 4'(MAX_PLANES)) begin
         eff_planes = 4'(MAX_PLANES);
      end else begin
         eff_planes = planes_ff;
      end
      eff_height = (height_ff == 16'd0) ? 16'd1 : height_ff;
      row_last   = ({1'b0, row_ff} + 17'd1) >= {1'b0, eff_height};
   end

   // Classification of the byte offered on the input channel.
   always_comb begin
      lit_need = {2'b0, req_data_byte} + 10'd1 + {2'b0, pos_ff};
      run_need = {2'b0, lit_ff} + {2'b0, pos_ff};
      cls_code = STATUS_OK;
      cls      = CLS_HEADER;
      if (err_flag_ff || phase_ff == PH_DONE) begin
         cls = CLS_IGNORE;
      end else if (mode_ff > MODE_BYTERUN1) begin
         cls      = CLS_ERROR;
         cls_code = STATUS_UNSUP;
      end else if (mode_ff == MODE_NONE) begin
         cls = CLS_STORE;
      end else begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (req_data_byte < HDR_NOP && lit_need > {2'b0, line_len}) begin
                  cls      = CLS_ERROR;
                  cls_code = STATUS_OVERRUN;
               end
            end
            PH_LITERAL: cls = CLS_STORE;
            PH_RUN: begin
               if (run_need > {2'b0, line_len}) begin
                  cls      = CLS_ERROR;
                  cls_code = STATUS_OVERRUN;
               end else if (lit_ff != 8'd0) begin
                  cls = CLS_STORE;
               end
            end
            default: cls = CLS_IGNORE;
         endcase
      end
   end

   // One plane byte merged into its 8-pixel word.
   always_comb begin
      exp_word   = expand_byte(byte_ff);
      new_word   = (plane_ff == 4'd0) ? exp_word
                                      : (rd_word_ff | (exp_word << plane_ff[2:0]));
      pos_next   = pos_ff + 8'd1;
      line_done  = pos_next >= line_len;
      last_col   = !in_mask_ff && (({1'b0, plane_ff} + 5'd1) >= {1'b0, eff_planes});
      emit       = last_col && !pos_next[0];
      grp_col    = {pos_ff[6:0] - 7'd1, 3'b000};
      width_left = eff_width - {1'b0, grp_col};
      if (eff_width > {1'b0, grp_col}) begin
         grp_vp = (width_left > 11'd16) ? 5'd16 : width_left[4:0];
      end else begin
         grp_vp = 5'd0;
      end
      grp_done = line_done && row_last;
      out_free = !out_valid_ff || rsp_ready;
   end

   // Decode state after a header byte or a store, including the end of a plane line or a row.
   always_comb begin
      plane_in   = plane_ff;
      in_mask_in = in_mask_ff;
      pos_in     = pos_ff;
      row_in     = row_ff;
      phase_in   = phase_ff;
      lit_in     = lit_ff;
      if (cmd.accept) begin
         if (mode_ff == MODE_BYTERUN1) begin
            if (cls == CLS_HEADER && phase_ff == PH_HEADER) begin
               if (req_data_byte < HDR_NOP) begin
                  lit_in   = req_data_byte + 8'd1;
                  phase_in = PH_LITERAL;
               end else if (req_data_byte > HDR_NOP) begin
                  lit_in   = 8'(RUN_BASE - {1'b0, req_data_byte});
                  phase_in = PH_RUN;
               end
            end else if ((cls == CLS_HEADER || cls == CLS_STORE) && phase_ff == PH_RUN) begin
               lit_in   = 8'd0;
               phase_in = PH_HEADER;
            end
         end
      end else if (cmd.write) begin
         pos_in = pos_next;
         if (line_done) begin
            pos_in   = 8'd0;
            phase_in = PH_HEADER;
            lit_in   = 8'd0;
            if (in_mask_ff || (last_col && !mask_ff)) begin
               in_mask_in = 1'b0;
               plane_in   = 4'd0;
               if (row_last) begin
                  phase_in = PH_DONE;
               end else begin
                  row_in = row_ff + 16'd1;
               end
            end else if (last_col) begin
               in_mask_in = 1'b1;
            end else begin
               plane_in = plane_ff + 4'd1;
            end
         end
         if (lit_step_ff && phase_in == PH_LITERAL) begin
            if (lit_in != 8'd0) begin
               lit_in = lit_in - 8'd1;
            end
            if (lit_in == 8'd0) begin
               phase_in = PH_HEADER;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= 11'd320;
         height_ff     <= 16'd200;
         planes_ff     <= 4'd5;
         mode_ff       <= MODE_BYTERUN1;
         mask_ff       <= 1'b0;
         plane_ff      <= 4'd0;
         in_mask_ff    <= 1'b0;
         pos_ff        <= 8'd0;
         row_ff        <= 16'd0;
         phase_ff      <= PH_HEADER;
         lit_ff        <= 8'd0;
         err_flag_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         plane_ff   <= plane_in;
         in_mask_ff <= in_mask_in;
         pos_ff     <= pos_in;
         row_ff     <= row_in;
         phase_ff   <= phase_in;
         lit_ff     <= lit_in;
         if (csr_write) begin
            unique case (csr_index)
               REG_IMAGE_WIDTH:  width_ff  <= csr_data[10:0];
               REG_IMAGE_HEIGHT: height_ff <= csr_data;
               REG_PLANE_COUNT:  planes_ff <= csr_data[3:0];
               REG_COMP_MODE:    mode_ff   <= csr_data[7:0];
               REG_MASK_PLANE:   mask_ff   <= csr_data[0];
               default: ;
            endcase
         end
         if (cmd.end_chk && ce_ff && phase_ff != PH_DONE) begin
            err_flag_ff <= 1'b1;
         end
         if (cmd.err_push) begin
            err_flag_ff <= 1'b1;
         end
         if (cmd.write && emit) begin
            pend_valid_ff <= 1'b1;
         end else if (cmd.flush) begin
            pend_valid_ff <= 1'b0;
         end
         if ((cmd.write && emit && pend_valid_ff) || cmd.flush || cmd.err_push) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         byte_ff     <= req_data_byte;
         ce_ff       <= req_chunk_end;
         lit_step_ff <= (mode_ff == MODE_BYTERUN1) && (phase_ff == PH_LITERAL);
         count_ff    <= (mode_ff == MODE_NONE || phase_ff == PH_LITERAL) ? 8'd1 : lit_ff;
         err_code_ff <= cls_code;
      end
      if (cmd.read) begin
         rd_word_ff <= store_mem[pos_ff[STORE_AW-1:0]];
      end
      if (cmd.write) begin
         count_ff <= count_ff - 8'd1;
         if (!in_mask_ff) begin
            store_mem[pos_ff[STORE_AW-1:0]] <= new_word;
            prev_word_ff <= new_word;
         end
      end
      if (cmd.end_chk && ce_ff && phase_ff != PH_DONE) begin
         pend_status_ff <= STATUS_EARLY;
         err_code_ff    <= STATUS_EARLY;
      end
      if (cmd.write && emit) begin
         pend_p1_ff     <= prev_word_ff;
         pend_p2_ff     <= new_word;
         pend_col_ff    <= grp_col;
         pend_row_ff    <= row_ff;
         pend_vp_ff     <= grp_vp;
         pend_status_ff <= STATUS_OK;
         pend_done_ff   <= grp_done;
      end
      if ((cmd.write && emit && pend_valid_ff) || cmd.flush) begin
         out_p1_ff     <= pend_p1_ff;
         out_p2_ff     <= pend_p2_ff;
         out_col_ff    <= pend_col_ff;
         out_row_ff    <= pend_row_ff;
         out_vp_ff     <= pend_vp_ff;
         out_status_ff <= pend_status_ff;
         out_done_ff   <= pend_done_ff;
         out_last_ff   <= cmd.flush;
      end else if (cmd.err_push) begin
         out_p1_ff     <= '0;
         out_p2_ff     <= '0;
         out_col_ff    <= '0;
         out_row_ff    <= row_ff;
         out_vp_ff     <= '0;
         out_status_ff <= err_code_ff;
         out_done_ff   <= 1'b0;
         out_last_ff   <= 1'b1;
      end
   end

   always_comb begin
      stat.cls        = cls;
      stat.store_last = (count_ff == 8'd1);
      stat.wr_stall   = emit && pend_valid_ff && !out_free;
      stat.pend_valid = pend_valid_ff;
      stat.end_err    = ce_ff && (phase_ff != PH_DONE) && !pend_valid_ff;
      stat.out_free   = out_free;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_pixels_first  = out_p1_ff;
   assign rsp_pixels_second = out_p2_ff;
   assign rsp_column        = out_col_ff;
   assign rsp_row           = out_row_ff;
   assign rsp_valid_pixels  = out_vp_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_last_of_item  = out_last_ff;
   assign rsp_image_done    = out_done_ff;
endmodule
`default_nettype wire

FILE: rtl/core/planar_byterun1_line_decoder_core.sv
// Sequence: a header byte is accepted and then end-checked; an ignored byte is only accepted.
// Each stored plane byte is a store read, then a merge and write; a literal byte or a run is
// accepted, stored, end-checked, and then any pending last group is handed over.
// Throughput: one byte at a time; the single-port line store read-modify-write sets the pace.
// A group transfer is held back only while the result register is still full.
// Reset is synchronous and active high; it restores configuration, decode state, valid flags.
`default_nettype none
module planar_byterun1_line_decoder_core (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [7:0]                 req_data_byte,
   input  wire logic                       req_chunk_end,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [pbr_pkg::CSR_IW-1:0] csr_index,
   input  wire logic [pbr_pkg::CSR_DW-1:0] csr_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [63:0]                     rsp_pixels_first,
   output logic [63:0]                     rsp_pixels_second,
   output logic [9:0]                      rsp_column,
   output logic [15:0]                     rsp_row,
   output logic [4:0]                      rsp_valid_pixels,
   output logic [1:0]                      rsp_status,
   output logic                            rsp_last_of_item,
   output logic                            rsp_image_done
);
   import pbr_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   pbr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pbr_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_data_byte     (req_data_byte),
      .req_chunk_end     (req_chunk_end),
      .csr_write         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_pixels_first  (rsp_pixels_first),
      .rsp_pixels_second (rsp_pixels_second),
      .rsp_column        (rsp_column),
      .rsp_row           (rsp_row),
      .rsp_valid_pixels  (rsp_valid_pixels),
      .rsp_status        (rsp_status),
      .rsp_last_of_item  (rsp_last_of_item),
      .rsp_image_done    (rsp_image_done)
   );

   // An error status always closes the results of its byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_last_of_item)
      else $error("error status on a result that does not close its byte");

   // After an error transfer the decoder goes silent.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_status != STATUS_OK |=> !rsp_valid)
      else $error("result produced after a sticky error");

   // The group that completes the image never carries a decode error.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_image_done |->
         rsp_status != STATUS_OVERRUN && rsp_status != STATUS_UNSUP)
      else $error("image completion flagged together with a decode error");

   // A stored byte never waits on the result register unless a group is pending.
   assert property (@(posedge clock) disable iff (reset)
      stat.wr_stall |-> stat.pend_valid && rsp_valid)
      else $error("store stalled without a pending group");
endmodule
`default_nettype wire
